### sv/argbfb_pkg.sv
package argbfb_pkg;

    localparam int unsigned ArgbW = 32;
    localparam int unsigned CoordW = 16;
    localparam int unsigned FmtW = 9;
    localparam int unsigned ModeW = 2;
    localparam int unsigned LineW = 16;
    localparam int unsigned ScreenW = 12;
    localparam int unsigned OffsW = 28;
    localparam int unsigned WordW = 32;
    localparam int unsigned ChanW = 8;
    localparam int unsigned NumChan = 4;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned STdataW = 64;
    localparam int unsigned MTdataW = 64;
    localparam int unsigned MTuserW = 2;

    // Channel order inside the format array.
    localparam int unsigned ChRed = 0;
    localparam int unsigned ChGreen = 1;
    localparam int unsigned ChBlue = 2;
    localparam int unsigned ChAlpha = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RED_FORMAT     = 3'd0,
        REG_GREEN_FORMAT   = 3'd1,
        REG_BLUE_FORMAT    = 3'd2,
        REG_ALPHA_FORMAT   = 3'd3,
        REG_PIXEL_MODE     = 3'd4,
        REG_LINE_BYTES     = 3'd5,
        REG_SCREEN_WIDTH   = 3'd6,
        REG_SCREEN_HEIGHT  = 3'd7
    } cfg_reg_t;

    typedef enum logic [ModeW-1:0] {
        MODE_NONE   = 2'd0,
        MODE_16BPP  = 2'd1,
        MODE_32BPP  = 2'd2,
        MODE_RSVD   = 2'd3
    } pixel_mode_t;

    typedef struct packed {
        logic [ArgbW-1:0]  argb;
        logic [CoordW-1:0] dest_x;
        logic [CoordW-1:0] dest_y;
    } pix_in_t;

    // Load strobes for the three pipeline registers.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ctl_t;

    // Store decision at the second stage, handed to the pixel packer.
    typedef struct packed {
        logic ok;
        logic wide;
    } store_flags_t;

    typedef logic [FmtW-1:0] fmt_arr_t [NumChan];
    typedef logic [ChanW-1:0] chan_arr_t [NumChan];

    // Keeps the top len bits of a channel; lengths above eight keep all eight.
    function automatic logic [ChanW-1:0] chan_trim(input logic [ChanW-1:0] chan,
                                                   input logic [FmtW-1:0] fmt);
        logic [3:0] len;
        logic [3:0] sh;
        logic [ChanW-1:0] kept;
        len = fmt[8:5];
        if (len > 4'd8) begin
            len = 4'd8;
        end
        sh = 4'd8 - len;
        kept = chan >> sh;
        if (len == 4'd0) begin
            kept = '0;
        end
        return kept;
    endfunction

    function automatic logic [WordW-1:0] chan_place(input logic [ChanW-1:0] kept,
                                                    input logic [FmtW-1:0] fmt);
        logic [WordW+ChanW-1:0] wide;
        wide = {{WordW{1'b0}}, kept} << fmt[4:0];
        return wide[WordW-1:0];
    endfunction

endpackage

### sv/argb_to_framebuffer_pixel_writer_core.sv
// Channel   Direction  Handshake         Contents
// s_axis    in         tvalid/tready     argb, dest_x, dest_y
// m_axis    out        tvalid/tready     byte_offset, pixel_word; flags in tuser
// cfg       in         cfg_wr_en         register index and value, no read-back
//
// One item per cycle sustained while m_tready is high; an item passes the clip
// stage, the row multiply stage and the offset add, each with its own register.
// An input skid register keeps s_tready free of any path from m_tready.
// Reset clears the valid bits and all configuration registers to zero.
// A stall holds every full stage; empty stages keep filling behind it.
module argb_to_framebuffer_pixel_writer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // argb [31:0], dest_x [47:32], dest_y [63:48]
    input  logic [argbfb_pkg::STdataW-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // byte_offset [27:0], pixel_word [59:28], zero [63:60]
    output logic [argbfb_pkg::MTdataW-1:0]      m_tdata,
    // write_enable [0], wide_store [1]
    output logic [argbfb_pkg::MTuserW-1:0]      m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [argbfb_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [argbfb_pkg::CfgDataW-1:0]     cfg_data
);

    argbfb_pkg::pix_in_t  in_item;
    argbfb_pkg::pix_in_t  sk_item;
    logic                 sk_valid;
    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    argbfb_pkg::pipe_ctl_t ctl;
    argbfb_pkg::store_flags_t flags2;
    argbfb_pkg::fmt_arr_t fmt;
    logic                 ok3;
    logic                 wide3;
    logic [argbfb_pkg::OffsW-1:0] offs3;
    logic [argbfb_pkg::WordW-1:0] word3;

    logic [argbfb_pkg::FmtW-1:0]    red_format_reg;
    logic [argbfb_pkg::FmtW-1:0]    green_format_reg;
    logic [argbfb_pkg::FmtW-1:0]    blue_format_reg;
    logic [argbfb_pkg::FmtW-1:0]    alpha_format_reg;
    logic [argbfb_pkg::ModeW-1:0]   pixel_mode_reg;
    logic [argbfb_pkg::LineW-1:0]   line_bytes_reg;
    logic [argbfb_pkg::ScreenW-1:0] screen_width_reg;
    logic [argbfb_pkg::ScreenW-1:0] screen_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_format_reg    <= '0;
            green_format_reg  <= '0;
            blue_format_reg   <= '0;
            alpha_format_reg  <= '0;
            pixel_mode_reg    <= '0;
            line_bytes_reg    <= '0;
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
        end else if (cfg_wr_en) begin
            case (argbfb_pkg::cfg_reg_t'(cfg_index))
                argbfb_pkg::REG_RED_FORMAT: begin
                    red_format_reg <= cfg_data[argbfb_pkg::FmtW-1:0];
                end
                argbfb_pkg::REG_GREEN_FORMAT: begin
                    green_format_reg <= cfg_data[argbfb_pkg::FmtW-1:0];
                end
                argbfb_pkg::REG_BLUE_FORMAT: begin
                    blue_format_reg <= cfg_data[argbfb_pkg::FmtW-1:0];
                end
                argbfb_pkg::REG_ALPHA_FORMAT: begin
                    alpha_format_reg <= cfg_data[argbfb_pkg::FmtW-1:0];
                end
                argbfb_pkg::REG_PIXEL_MODE: begin
                    pixel_mode_reg <= cfg_data[argbfb_pkg::ModeW-1:0];
                end
                argbfb_pkg::REG_LINE_BYTES: begin
                    line_bytes_reg <= cfg_data[argbfb_pkg::LineW-1:0];
                end
                argbfb_pkg::REG_SCREEN_WIDTH: begin
                    screen_width_reg <= cfg_data[argbfb_pkg::ScreenW-1:0];
                end
                argbfb_pkg::REG_SCREEN_HEIGHT: begin
                    screen_height_reg <= cfg_data[argbfb_pkg::ScreenW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign fmt[argbfb_pkg::ChRed]   = red_format_reg;
    assign fmt[argbfb_pkg::ChGreen] = green_format_reg;
    assign fmt[argbfb_pkg::ChBlue]  = blue_format_reg;
    assign fmt[argbfb_pkg::ChAlpha] = alpha_format_reg;

    assign in_item.argb   = s_tdata[31:0];
    assign in_item.dest_x = s_tdata[47:32];
    assign in_item.dest_y = s_tdata[63:48];

    argbfb_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (sk_valid),
        .out_ready (rdy1),
        .out_data  (sk_item)
    );

    // A stage takes new data whenever it is empty or its content moves on.
    assign rdy3 = !v3_reg || m_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ctl.ld1 = rdy1 && sk_valid;
    assign ctl.ld2 = rdy2 && v1_reg;
    assign ctl.ld3 = rdy3 && v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= sk_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    argbfb_addr u_addr (
        .aclk          (aclk),
        .ctl           (ctl),
        .dest_x        (sk_item.dest_x),
        .dest_y        (sk_item.dest_y),
        .pixel_mode    (pixel_mode_reg),
        .line_bytes    (line_bytes_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .flags2        (flags2),
        .ok3           (ok3),
        .wide3         (wide3),
        .offs3         (offs3)
    );

    argbfb_pack u_pack (
        .aclk   (aclk),
        .ctl    (ctl),
        .argb   (sk_item.argb),
        .fmt    (fmt),
        .flags2 (flags2),
        .word3  (word3)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {4'b0000, word3, offs3};
    assign m_tuser  = {wide3, ok3};

`ifndef SYNTHESIS
    // A skipped store carries no offset, no word and no width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("skipped store carries nonzero fields");

    // A narrow store never has bits above the low half of the word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && !m_tuser[1] |-> m_tdata[59:44] == '0)
        else $error("narrow store has upper word bits set");

    // The skid register only fills when the whole pipeline is backed up.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && v3_reg)
        else $error("input stalled with an empty pipeline stage");

    // A stalled output keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
`endif

endmodule

### sv/argbfb_skid.sv
module argbfb_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  argbfb_pkg::pix_in_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output argbfb_pkg::pix_in_t out_data
);

    logic                full_reg;
    logic                full_next;
    argbfb_pkg::pix_in_t hold_reg;

    assign in_ready  = !full_reg;
    assign out_valid = full_reg || in_valid;
    assign out_data  = full_reg ? hold_reg : in_data;

    always_comb begin
        full_next = full_reg;
        if (!full_reg && in_valid && !out_ready) begin
            full_next = 1'b1;
        end else if (full_reg && out_ready) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!full_reg && in_valid && !out_ready) begin
            hold_reg <= in_data;
        end
    end

endmodule

### sv/argbfb_addr.sv
module argbfb_addr (
    input  logic                                     aclk,
    input  argbfb_pkg::pipe_ctl_t                    ctl,
    input  logic [argbfb_pkg::CoordW-1:0]            dest_x,
    input  logic [argbfb_pkg::CoordW-1:0]            dest_y,
    input  logic [argbfb_pkg::ModeW-1:0]             pixel_mode,
    input  logic [argbfb_pkg::LineW-1:0]             line_bytes,
    input  logic [argbfb_pkg::ScreenW-1:0]           screen_width,
    input  logic [argbfb_pkg::ScreenW-1:0]           screen_height,
    output argbfb_pkg::store_flags_t                 flags2,
    output logic                                     ok3,
    output logic                                     wide3,
    output logic [argbfb_pkg::OffsW-1:0]             offs3
);

    localparam int unsigned SW = argbfb_pkg::ScreenW;
    localparam int unsigned OW = argbfb_pkg::OffsW;

    logic          on_screen;
    logic          supported;
    logic          ok1_reg;
    logic          wide1_reg;
    logic [SW-1:0] x1_reg;
    logic [SW-1:0] y1_reg;
    logic          ok2_reg;
    logic          wide2_reg;
    logic [SW-1:0] x2_reg;
    logic [OW-1:0] row2_reg;
    logic [OW-1:0] col_bytes;
    logic [OW-1:0] offs_sum;
    logic          ok3_reg;
    logic          wide3_reg;
    logic [OW-1:0] offs3_reg;

    // Negative coordinates fail on the sign bit; the rest compares unsigned.
    assign on_screen = !dest_x[argbfb_pkg::CoordW-1] && !dest_y[argbfb_pkg::CoordW-1]
                    && ({1'b0, dest_x[argbfb_pkg::CoordW-2:0]}
                        < {{(argbfb_pkg::CoordW-SW){1'b0}}, screen_width})
                    && ({1'b0, dest_y[argbfb_pkg::CoordW-2:0]}
                        < {{(argbfb_pkg::CoordW-SW){1'b0}}, screen_height});
    assign supported = (pixel_mode == argbfb_pkg::MODE_16BPP)
                    || (pixel_mode == argbfb_pkg::MODE_32BPP);

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            ok1_reg   <= on_screen && supported;
            wide1_reg <= (pixel_mode == argbfb_pkg::MODE_32BPP);
            x1_reg    <= dest_x[SW-1:0];
            y1_reg    <= dest_y[SW-1:0];
        end
    end

    // A visible row is below 4096, so the product fits the offset width.
    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            ok2_reg   <= ok1_reg;
            wide2_reg <= wide1_reg;
            x2_reg    <= x1_reg;
            row2_reg  <= OW'(y1_reg * line_bytes);
        end
    end

    assign col_bytes = wide2_reg ? {{(OW-SW-2){1'b0}}, x2_reg, 2'b00}
                                 : {{(OW-SW-1){1'b0}}, x2_reg, 1'b0};
    assign offs_sum  = row2_reg + col_bytes;

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            ok3_reg   <= ok2_reg;
            wide3_reg <= ok2_reg && wide2_reg;
            offs3_reg <= ok2_reg ? offs_sum : '0;
        end
    end

    assign flags2.ok   = ok2_reg;
    assign flags2.wide = wide2_reg;
    assign ok3   = ok3_reg;
    assign wide3 = wide3_reg;
    assign offs3 = offs3_reg;

endmodule

### sv/argbfb_pack.sv
module argbfb_pack (
    input  logic                             aclk,
    input  argbfb_pkg::pipe_ctl_t            ctl,
    input  logic [argbfb_pkg::ArgbW-1:0]     argb,
    input  argbfb_pkg::fmt_arr_t             fmt,
    input  argbfb_pkg::store_flags_t         flags2,
    output logic [argbfb_pkg::WordW-1:0]     word3
);

    localparam int unsigned WW = argbfb_pkg::WordW;

    argbfb_pkg::chan_arr_t chan;
    argbfb_pkg::chan_arr_t kept1_reg;
    logic [WW-1:0]         placed;
    logic [WW-1:0]         word2_reg;
    logic [WW-1:0]         word_sel;
    logic [WW-1:0]         word3_reg;

    assign chan[argbfb_pkg::ChRed]   = argb[23:16];
    assign chan[argbfb_pkg::ChGreen] = argb[15:8];
    assign chan[argbfb_pkg::ChBlue]  = argb[7:0];
    assign chan[argbfb_pkg::ChAlpha] = argb[31:24];

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            for (int i = 0; i < argbfb_pkg::NumChan; i++) begin
                kept1_reg[i] <= argbfb_pkg::chan_trim(chan[i], fmt[i]);
            end
        end
    end

    always_comb begin
        placed = '0;
        for (int i = 0; i < argbfb_pkg::NumChan; i++) begin
            placed = placed | argbfb_pkg::chan_place(kept1_reg[i], fmt[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            word2_reg <= placed;
        end
    end

    always_comb begin
        word_sel = word2_reg;
        if (!flags2.wide) begin
            word_sel = {{(WW/2){1'b0}}, word2_reg[WW/2-1:0]};
        end
        if (!flags2.ok) begin
            word_sel = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            word3_reg <= word_sel;
        end
    end

    assign word3 = word3_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import argbfb_pkg::*;

    localparam int QuietLimit = 4000;
    localparam int DrainCycles = 8;

    // One framebuffer store as the block should emit it.
    typedef struct packed {
        logic             we;
        logic [OffsW-1:0] offs;
        logic [WordW-1:0] word;
        logic             wide;
    } fb_store_t;

    class fb_store_checker;
        logic [FmtW-1:0]    chan_fmt [NumChan];
        pixel_mode_t        mode;
        logic [LineW-1:0]   line_bytes;
        logic [ScreenW-1:0] scr_w;
        logic [ScreenW-1:0] scr_h;
        fb_store_t          expected_stores [$];
        int unsigned        mismatches;
        int unsigned        stores_checked;
        int unsigned        writes_seen;
        int unsigned        wide_seen;

        function new();
            foreach (chan_fmt[i]) chan_fmt[i] = '0;
            mode = MODE_NONE;
            line_bytes = '0;
            scr_w = '0;
            scr_h = '0;
            mismatches = 0;
            stores_checked = 0;
            writes_seen = 0;
            wide_seen = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
            case (idx)
                REG_RED_FORMAT:    chan_fmt[ChRed] = val[FmtW-1:0];
                REG_GREEN_FORMAT:  chan_fmt[ChGreen] = val[FmtW-1:0];
                REG_BLUE_FORMAT:   chan_fmt[ChBlue] = val[FmtW-1:0];
                REG_ALPHA_FORMAT:  chan_fmt[ChAlpha] = val[FmtW-1:0];
                REG_PIXEL_MODE:    mode = pixel_mode_t'(val[ModeW-1:0]);
                REG_LINE_BYTES:    line_bytes = val[LineW-1:0];
                REG_SCREEN_WIDTH:  scr_w = val[ScreenW-1:0];
                REG_SCREEN_HEIGHT: scr_h = val[ScreenW-1:0];
                default: ;
            endcase
        endfunction

        // Lengths past eight keep the whole byte; bits shifted past bit 31 fall off.
        function logic [WordW-1:0] keep_and_shift(logic [ChanW-1:0] chan,
                                                  logic [FmtW-1:0] fmt);
            logic [3:0]             len;
            logic [ChanW-1:0]       kept;
            logic [WordW+ChanW-1:0] shifted;
            len = fmt[8:5];
            if (len == 4'd0) return '0;
            if (len > 4'd8) len = 4'd8;
            kept = chan >> (4'd8 - len);
            shifted = {{WordW{1'b0}}, kept} << fmt[4:0];
            return shifted[WordW-1:0];
        endfunction

        function fb_store_t predict_store(logic [ArgbW-1:0] argb,
                                          logic signed [CoordW-1:0] x,
                                          logic signed [CoordW-1:0] y);
            fb_store_t        s;
            logic [WordW-1:0] word;
            longint           offs;
            bit               on_screen;
            s = '0;
            on_screen = int'(x) >= 0 && int'(y) >= 0 &&
                        int'(x) < int'(scr_w) && int'(y) < int'(scr_h);
            if (!on_screen || !(mode == MODE_16BPP || mode == MODE_32BPP)) return s;
            word = keep_and_shift(argb[23:16], chan_fmt[ChRed])
                 | keep_and_shift(argb[15:8], chan_fmt[ChGreen])
                 | keep_and_shift(argb[7:0], chan_fmt[ChBlue])
                 | keep_and_shift(argb[31:24], chan_fmt[ChAlpha]);
            if (mode == MODE_16BPP) word[31:16] = '0;
            offs = longint'(y) * longint'(line_bytes)
                 + longint'(x) * ((mode == MODE_32BPP) ? 4 : 2);
            s.we = 1'b1;
            s.offs = OffsW'(offs);
            s.word = word;
            s.wide = (mode == MODE_32BPP);
            return s;
        endfunction

        function void note_pixel(logic [ArgbW-1:0] argb, logic signed [CoordW-1:0] x,
                                 logic signed [CoordW-1:0] y);
            expected_stores.push_back(predict_store(argb, x, y));
        endfunction

        function void check_store(logic [MTdataW-1:0] tdata, logic [MTuserW-1:0] tuser);
            fb_store_t exp_st;
            if (expected_stores.size() == 0) begin
                $error("store arrived with none outstanding: tdata %h tuser %b",
                       tdata, tuser);
                mismatches++;
                return;
            end
            exp_st = expected_stores.pop_front();
            stores_checked++;
            if (exp_st.we) writes_seen++;
            if (exp_st.wide) wide_seen++;
            if (tuser[0] !== exp_st.we) begin
                $error("write_enable: expected %0b, got %0b", exp_st.we, tuser[0]);
                mismatches++;
            end
            if (tdata[27:0] !== exp_st.offs) begin
                $error("byte_offset: expected %0h, got %0h", exp_st.offs, tdata[27:0]);
                mismatches++;
            end
            if (tdata[59:28] !== exp_st.word) begin
                $error("pixel_word: expected %h, got %h", exp_st.word, tdata[59:28]);
                mismatches++;
            end
            if (tuser[1] !== exp_st.wide) begin
                $error("wide_store: expected %0b, got %0b", exp_st.wide, tuser[1]);
                mismatches++;
            end
            if (tdata[63:60] !== 4'h0) begin
                $error("tdata padding: expected 0, got %0h", tdata[63:60]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_stores.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [STdataW-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MTdataW-1:0]   m_tdata;
    logic [MTuserW-1:0]   m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data = '0;

    fb_store_checker store_chk = new();
    bit          idle_free = 1'b0;
    int unsigned pixels_sent = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;

    always #5 aclk = ~aclk;

    argb_to_framebuffer_pixel_writer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        if (idle_free) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random back-pressure, checked at every accepted item.
    int stall_left = 0;
    always @(posedge aclk) begin
        int gap;
        if (aresetn) begin
            if (m_tvalid && m_tready) store_chk.check_store(m_tdata, m_tuser);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                gap = pick_gap();
                m_tready <= (gap == 0);
                if (gap > 0) stall_left = gap - 1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Leaves s_tvalid high after acceptance so back-to-back items need no toggle.
    task automatic send_pixel(input logic [ArgbW-1:0] argb,
                              input logic signed [CoordW-1:0] x,
                              input logic signed [CoordW-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x, argb};
        do @(posedge aclk); while (!s_tready);
        store_chk.note_pixel(argb, x, y);
        pixels_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (store_chk.pending() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        store_chk.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [FmtW-1:0] red, input logic [FmtW-1:0] green,
                               input logic [FmtW-1:0] blue, input logic [FmtW-1:0] alpha,
                               input pixel_mode_t mode, input logic [LineW-1:0] lb,
                               input logic [ScreenW-1:0] w, input logic [ScreenW-1:0] h);
        wait_drain();
        write_reg(REG_RED_FORMAT, CfgDataW'(red));
        write_reg(REG_GREEN_FORMAT, CfgDataW'(green));
        write_reg(REG_BLUE_FORMAT, CfgDataW'(blue));
        write_reg(REG_ALPHA_FORMAT, CfgDataW'(alpha));
        write_reg(REG_PIXEL_MODE, CfgDataW'(mode));
        write_reg(REG_LINE_BYTES, CfgDataW'(lb));
        write_reg(REG_SCREEN_WIDTH, CfgDataW'(w));
        write_reg(REG_SCREEN_HEIGHT, CfgDataW'(h));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mostly legal lengths; now and then the full nine bits, so lengths 9..15 appear.
    function automatic logic [FmtW-1:0] rand_fmt();
        case ($urandom_range(0, 9))
            0: return FmtW'($urandom());
            1: return FmtW'($urandom_range(0, 31));
            default: return FmtW'($urandom_range(1, 8) * 32 + $urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [ScreenW-1:0] rand_extent();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return ScreenW'($urandom_range(1, 16));
            default: return ScreenW'($urandom_range(1, 4095));
        endcase
    endfunction

    // Mostly on screen, with the clip edges and the full signed range mixed in.
    function automatic logic signed [CoordW-1:0] pick_coord(input int lim);
        case ($urandom_range(0, 9))
            0: return CoordW'($urandom());
            1: return CoordW'(lim);
            2: return CoordW'(lim - 1);
            3: return -16'sd1;
            4: return 16'sd0;
            default: begin
                if (lim == 0) return CoordW'($urandom());
                return CoordW'($urandom_range(0, lim - 1));
            end
        endcase
    endfunction

    task automatic load_random_config();
        pixel_mode_t      mode;
        logic [LineW-1:0] lb;
        case ($urandom_range(0, 9))
            0: mode = MODE_NONE;
            1: mode = MODE_RSVD;
            2, 3, 4, 5: mode = MODE_16BPP;
            default: mode = MODE_32BPP;
        endcase
        case ($urandom_range(0, 4))
            0: lb = '0;
            1: lb = '1;
            default: lb = LineW'($urandom());
        endcase
        load_config(rand_fmt(), rand_fmt(), rand_fmt(), rand_fmt(), mode, lb,
                    rand_extent(), rand_extent());
    endtask

    task automatic run_random_phase(input int n, input bit no_idle, input bit mid_pause);
        idle_free = no_idle;
        for (int i = 0; i < n; i++) begin
            if (mid_pause && i == n / 2) wait_drain();
            send_pixel($urandom(), pick_coord(int'(store_chk.scr_w)),
                       pick_coord(int'(store_chk.scr_h)));
        end
        idle_free = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers still at reset: unsupported depth and empty screen, no stores.
        send_pixel(32'hFFFF_FFFF, 16'sd0, 16'sd0);
        send_pixel(32'h0000_0000, 16'sd32767, -16'sd32768);

        // RGB565 on a 640x480 screen, corners and every clip edge.
        load_config(9'd171, 9'd197, 9'd160, 9'd0, MODE_16BPP, 16'd1280, 12'd640, 12'd480);
        send_pixel(32'hFFFF_FFFF, 16'sd0, 16'sd0);
        send_pixel(32'h0000_0000, 16'sd639, 16'sd479);
        send_pixel(32'h1234_5678, 16'sd640, 16'sd0);
        send_pixel(32'h8765_4321, 16'sd0, 16'sd480);
        send_pixel(32'hFF00_FF00, -16'sd1, 16'sd5);
        send_pixel(32'h00FF_00FF, 16'sd5, -16'sd1);
        send_pixel(32'hA5A5_A5A5, -16'sd32768, -16'sd32768);
        send_pixel(32'h5A5A_5A5A, 16'sd32767, 16'sd32767);
        send_pixel(32'h8080_8080, 16'sd320, 16'sd240);

        // ARGB8888 at the largest screen and line length.
        load_config(9'd272, 9'd264, 9'd256, 9'd280, MODE_32BPP, 16'hFFFF, 12'hFFF, 12'hFFF);
        send_pixel(32'hFFFF_FFFF, 16'sd4094, 16'sd4094);
        send_pixel(32'h0102_0304, 16'sd0, 16'sd0);
        send_pixel(32'hFFFF_FFFF, 16'sd4095, 16'sd4094);
        send_pixel(32'hAABB_CCDD, 16'sd100, 16'sd200);

        // Red with an oversized length, green with zero length, blue and alpha
        // placed high so that 16-bit mode drops them; one-pixel screen.
        load_config(9'd480, 9'd7, 9'd287, 9'd126, MODE_16BPP, 16'hFFFF, 12'd1, 12'd1);
        send_pixel(32'hFFFF_FFFF, 16'sd0, 16'sd0);
        send_pixel(32'h7F7F_7F7F, 16'sd0, 16'sd0);
        send_pixel(32'hFFFF_FFFF, 16'sd1, 16'sd0);

        // Reserved depth, then zero width, then zero height: nothing is stored.
        load_config(9'd272, 9'd264, 9'd256, 9'd280, MODE_RSVD, 16'd400, 12'd100, 12'd100);
        send_pixel(32'hFFFF_FFFF, 16'sd10, 16'sd10);
        load_config(9'd272, 9'd264, 9'd256, 9'd280, MODE_32BPP, 16'd400, 12'd0, 12'd100);
        send_pixel(32'hFFFF_FFFF, 16'sd0, 16'sd0);
        load_config(9'd272, 9'd264, 9'd256, 9'd280, MODE_32BPP, 16'd400, 12'd100, 12'd0);
        send_pixel(32'hFFFF_FFFF, 16'sd0, 16'sd0);

        // Every register but the pixel mode at its top value, then near its bottom.
        load_config('1, '1, '1, '1, MODE_32BPP, '1, '1, '1);
        run_random_phase(200, 1'b0, 1'b0);
        load_config('0, '0, '0, '0, MODE_16BPP, '0, 12'd1, 12'd1);
        run_random_phase(150, 1'b0, 1'b0);

        for (int p = 0; p < 6; p++) begin
            load_random_config();
            run_random_phase(215, p == 0 || p == 3, p == 2);
        end

        wait_drain();
        $display("Sent %0d pixel items under %0d register settings.", pixels_sent,
                 settings_used);
        $display("Checked %0d results: %0d stores (%0d wide), the rest clipped or no depth.",
                 store_chk.stores_checked, store_chk.writes_seen, store_chk.wide_seen);
        if (store_chk.mismatches == 0 && store_chk.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### argb_to_framebuffer_pixel_writer_core.f
sv/argbfb_pkg.sv
sv/argbfb_skid.sv
sv/argbfb_addr.sv
sv/argbfb_pack.sv
sv/argb_to_framebuffer_pixel_writer_core.sv
tb/tb_top.sv
